>>> rtl/bpue_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpue_pkg: shared types and constants for the bit-field pack/unpack engine
// Request and status codes, the sequencer states, store geometry and the
// bit-order and mask helper functions.
// ---------------------------------------------------------------------------
package bpue_pkg;

    // store geometry
    localparam int BUF_BYTES = 256;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int BUF_BITS  = BUF_BYTES * 8;

    // field geometry
    localparam int POS_W     = 11;
    localparam int WIDTH_W   = 7;
    localparam int VALUE_W   = 64;
    localparam int END_W     = 12;
    localparam int WIN_W     = VALUE_W + 8;
    localparam int NB_W      = 4;
    localparam int NB_MAX    = (VALUE_W / 8) + 1;

    // request codes
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_PACK   = 2'd1,
        REQ_UNPACK = 2'd2
    } req_t;

    // status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_WIDTH = 2'd1,
        STATUS_NO_ROOM   = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_ZERO,
        ST_ALIGN,
        ST_RUN,
        ST_POST_ALIGN,
        ST_POST_ORDER,
        ST_POST_SIGN,
        ST_DONE
    } state_t;

    // reverse the bits of a byte
    function automatic logic [7:0] rev8(input logic [7:0] d);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = d[7 - i];
        end
        return r;
    endfunction

    // reverse the bits of a value word
    function automatic logic [VALUE_W-1:0] rev64(input logic [VALUE_W-1:0] d);
        logic [VALUE_W-1:0] r;
        for (int i = 0; i < VALUE_W; i++) begin
            r[i] = d[VALUE_W - 1 - i];
        end
        return r;
    endfunction

    // w low ones
    function automatic logic [VALUE_W-1:0] ones64(input logic [WIDTH_W-1:0] w);
        logic [VALUE_W:0] t;
        t = ({{VALUE_W{1'b0}}, 1'b1} << w) - {{VALUE_W{1'b0}}, 1'b1};
        return t[VALUE_W-1:0];
    endfunction

endpackage

>>> rtl/bpue_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpue_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bpue_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bitfield_pack_unpack_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitfield_pack_unpack_engine: bit-field insert/extract over a byte store
// Clear, pack and unpack requests against a 256-byte store with a length.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready), one result per request
//   leaves on the m_ channel (valid/ready). A transfer happens when valid and
//   ready are both high at a rising edge of aclk.
//   The engine works on one request at a time. The field moves through a
//   72-bit window register one byte per cycle, against a store RAM with a
//   registered read port:
//     clear, rejected, past-end : decode, then straight to the output
//     unpack                    : nine byte reads, then alignment, bit order and sign
//     pack                      : one read-modify-write per byte the
//                                 field spans (1 to 9), after zero bytes
//                                 are appended when the field starts
//                                 past the current end of the buffer
//                                 (up to 255 zero bytes)
//   s_ready rises again once the result sits in the output register, so the
//   next request is taken while the result waits. If the receiver stalls,
//   the engine holds its following result until the output register frees.
//   aresetn (synchronous, active low) empties the buffer and drops any
//   pending result; store contents are not cleared.
// ---------------------------------------------------------------------------
module bitfield_pack_unpack_engine (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_big_endian,
    input  logic               s_signed_mode,
    input  logic [10:0]        s_bit_pos,
    input  logic [6:0]         s_field_width,
    input  logic [63:0]        s_field_value,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_read_value,
    output logic [11:0]        m_end_position,
    output logic [8:0]         m_byte_count,
    output logic [1:0]         m_status
);

    localparam int AW  = bpue_pkg::ADDR_W;
    localparam int LW  = bpue_pkg::LEN_W;
    localparam int PW  = bpue_pkg::POS_W;
    localparam int WW  = bpue_pkg::WIDTH_W;
    localparam int VW  = bpue_pkg::VALUE_W;
    localparam int EW  = bpue_pkg::END_W;
    localparam int XW  = bpue_pkg::WIN_W;
    localparam int NW  = bpue_pkg::NB_W;

    bpue_pkg::state_t state_reg, state_next;

    // request registers
    logic [1:0]    req_reg, req_next;
    logic          be_reg, be_next;
    logic          sgn_reg, sgn_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [WW-1:0] w_reg, w_next;
    logic [VW-1:0] val_reg, val_next;

    // work registers
    logic [XW-1:0] win_reg, win_next;
    logic [XW-1:0] mask_reg, mask_next;
    logic [WW-1:0] weff_reg, weff_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] need_reg, need_next;
    logic [AW-1:0] first_reg, first_next;
    logic [NW-1:0] nb_reg, nb_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [NW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [EW-1:0] endp_reg, endp_next;
    logic [1:0]    status_reg, status_next;
    logic          rv_live_reg, rv_live_next;

    // output registers
    logic          m_valid_reg, m_valid_next;
    logic [VW-1:0] m_read_value_reg, m_read_value_next;
    logic [EW-1:0] m_end_position_reg, m_end_position_next;
    logic [LW-1:0] m_byte_count_reg, m_byte_count_next;
    logic [1:0]    m_status_reg, m_status_next;

    // ram port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic [7:0]    ram_rd_data;

    // decode arithmetic
    logic [EW-1:0] end_bits;
    logic [EW-1:0] end_m1;
    logic [EW-1:0] need_sum;
    logic [EW-1:0] lim_bits;
    logic [EW-1:0] rem_bits;
    logic          pack_bad;
    logic          pack_over;
    logic          unpack_bad;
    logic          unpack_past;
    logic [WW-1:0] weff_calc;
    logic [AW-1:0] last_byte;

    // byte merge
    logic [7:0]    old_byte;
    logic [7:0]    s_old;
    logic [7:0]    s_new;
    logic [7:0]    merged_byte;
    logic [7:0]    s_rd_byte;
    logic          run_done;
    logic          fill_done;
    logic [5:0]    sign_idx;

    bpue_ram #(
        .DATA_W (8),
        .DEPTH  (bpue_pkg::BUF_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    // request geometry
    always_comb begin
        end_bits    = EW'(pos_reg) + EW'(w_reg);
        end_m1      = end_bits - EW'(1);
        need_sum    = end_bits + EW'(7);
        last_byte   = end_m1[AW+2:3];
        lim_bits    = {len_reg, 3'b000};
        rem_bits    = lim_bits - EW'(pos_reg);
        pack_bad    = (w_reg == '0) || (w_reg > WW'(VW));
        pack_over   = end_bits > EW'(bpue_pkg::BUF_BITS);
        unpack_bad  = w_reg > WW'(VW);
        unpack_past = EW'(pos_reg) >= lim_bits;
        weff_calc   = (EW'(w_reg) > rem_bits) ? rem_bits[WW-1:0] : w_reg;
    end

    // byte merge in stream bit order
    always_comb begin
        old_byte    = (LW'(pend_addr_reg) >= len_reg) ? 8'h00 : ram_rd_data;
        s_old       = be_reg ? bpue_pkg::rev8(old_byte) : old_byte;
        s_new       = (s_old & ~mask_reg[7:0]) | (win_reg[7:0] & mask_reg[7:0]);
        merged_byte = be_reg ? bpue_pkg::rev8(s_new) : s_new;
        s_rd_byte   = be_reg ? bpue_pkg::rev8(ram_rd_data) : ram_rd_data;
        run_done    = (rd_cnt_reg == nb_reg) && !pend_reg;
        fill_done   = fill_reg == LW'(first_reg);
        sign_idx    = 6'(weff_reg - WW'(1));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpue_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bpue_pkg::ST_DECODE;
                end
            end
            bpue_pkg::ST_DECODE: begin
                case (req_reg)
                    bpue_pkg::REQ_PACK: begin
                        state_next = (pack_bad || pack_over) ? bpue_pkg::ST_DONE
                                                             : bpue_pkg::ST_PREP;
                    end
                    bpue_pkg::REQ_UNPACK: begin
                        state_next = (unpack_bad || unpack_past) ? bpue_pkg::ST_DONE
                                                                 : bpue_pkg::ST_RUN;
                    end
                    default: begin
                        state_next = bpue_pkg::ST_DONE;
                    end
                endcase
            end
            bpue_pkg::ST_PREP: begin
                state_next = (LW'(first_reg) > len_reg) ? bpue_pkg::ST_ZERO
                                                        : bpue_pkg::ST_ALIGN;
            end
            bpue_pkg::ST_ZERO: begin
                if (fill_done) begin
                    state_next = bpue_pkg::ST_ALIGN;
                end
            end
            bpue_pkg::ST_ALIGN: begin
                state_next = bpue_pkg::ST_RUN;
            end
            bpue_pkg::ST_RUN: begin
                if (run_done) begin
                    state_next = (req_reg == bpue_pkg::REQ_PACK) ? bpue_pkg::ST_DONE
                                                                 : bpue_pkg::ST_POST_ALIGN;
                end
            end
            bpue_pkg::ST_POST_ALIGN: begin
                state_next = bpue_pkg::ST_POST_ORDER;
            end
            bpue_pkg::ST_POST_ORDER: begin
                state_next = bpue_pkg::ST_POST_SIGN;
            end
            bpue_pkg::ST_POST_SIGN: begin
                state_next = bpue_pkg::ST_DONE;
            end
            bpue_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = bpue_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpue_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and ram control
    always_comb begin
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_addr_reg;
        ram_wr_data = merged_byte;
        unique case (state_reg)
            bpue_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            bpue_pkg::ST_ZERO: begin
                ram_wr_en   = !fill_done;
                ram_wr_addr = fill_reg[AW-1:0];
                ram_wr_data = 8'h00;
            end
            bpue_pkg::ST_RUN: begin
                ram_wr_en = pend_reg && (req_reg == bpue_pkg::REQ_PACK);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        req_next            = req_reg;
        be_next             = be_reg;
        sgn_next            = sgn_reg;
        pos_next            = pos_reg;
        w_next              = w_reg;
        val_next            = val_reg;
        win_next            = win_reg;
        mask_next           = mask_reg;
        weff_next           = weff_reg;
        len_next            = len_reg;
        need_next           = need_reg;
        first_next          = first_reg;
        nb_next             = nb_reg;
        rd_addr_next        = rd_addr_reg;
        rd_cnt_next         = rd_cnt_reg;
        pend_next           = pend_reg;
        pend_addr_next      = pend_addr_reg;
        fill_next           = fill_reg;
        endp_next           = endp_reg;
        status_next         = status_reg;
        rv_live_next        = rv_live_reg;
        m_valid_next        = m_valid_reg;
        m_read_value_next   = m_read_value_reg;
        m_end_position_next = m_end_position_reg;
        m_byte_count_next   = m_byte_count_reg;
        m_status_next       = m_status_reg;

        // result leaves on output transfer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            bpue_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_req_type;
                    be_next  = s_big_endian;
                    sgn_next = s_signed_mode;
                    pos_next = s_bit_pos;
                    w_next   = s_field_width;
                    val_next = s_field_value;
                end
            end
            bpue_pkg::ST_DECODE: begin
                status_next  = bpue_pkg::STATUS_OK;
                endp_next    = '0;
                rv_live_next = 1'b0;
                first_next   = pos_reg[AW+2:3];
                need_next    = need_sum[LW+2:3];
                pend_next    = 1'b0;
                rd_cnt_next  = '0;
                rd_addr_next = pos_reg[AW+2:3];
                case (req_reg)
                    bpue_pkg::REQ_CLEAR: begin
                        len_next = '0;
                    end
                    bpue_pkg::REQ_PACK: begin
                        if (pack_bad) begin
                            status_next = bpue_pkg::STATUS_BAD_WIDTH;
                        end else if (pack_over) begin
                            status_next = bpue_pkg::STATUS_NO_ROOM;
                        end else begin
                            endp_next = end_bits;
                            nb_next   = NW'(last_byte - pos_reg[AW+2:3]) + NW'(1);
                        end
                    end
                    bpue_pkg::REQ_UNPACK: begin
                        if (unpack_bad) begin
                            status_next = bpue_pkg::STATUS_BAD_WIDTH;
                        end else if (!unpack_past) begin
                            rv_live_next = 1'b1;
                            weff_next    = weff_calc;
                            nb_next      = NW'(bpue_pkg::NB_MAX);
                            win_next     = '0;
                        end
                    end
                    default: begin
                        status_next = bpue_pkg::STATUS_OK;
                    end
                endcase
            end
            bpue_pkg::ST_PREP: begin
                // field bits in stream order, first stream bit at bit 0
                if (be_reg) begin
                    win_next = {8'h00, bpue_pkg::rev64(val_reg) >> (WW'(VW) - w_reg)};
                end else begin
                    win_next = {8'h00, val_reg & bpue_pkg::ones64(w_reg)};
                end
                mask_next = {8'h00, bpue_pkg::ones64(w_reg)};
                fill_next = len_reg;
            end
            bpue_pkg::ST_ZERO: begin
                // append zero bytes up to the field's first byte
                if (!fill_done) begin
                    fill_next = fill_reg + LW'(1);
                end
            end
            bpue_pkg::ST_ALIGN: begin
                win_next  = win_reg << pos_reg[2:0];
                mask_next = mask_reg << pos_reg[2:0];
            end
            bpue_pkg::ST_RUN: begin
                // issue one byte read per cycle
                if (rd_cnt_reg != nb_reg) begin
                    rd_addr_next   = rd_addr_reg + AW'(1);
                    rd_cnt_next    = rd_cnt_reg + NW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                end else begin
                    pend_next = 1'b0;
                end
                // consume the byte read last cycle
                if (pend_reg) begin
                    if (req_reg == bpue_pkg::REQ_PACK) begin
                        win_next  = win_reg >> 8;
                        mask_next = mask_reg >> 8;
                    end else begin
                        win_next = {s_rd_byte, win_reg[XW-1:8]};
                    end
                end
                if (run_done && (req_reg == bpue_pkg::REQ_PACK)) begin
                    len_next = (need_reg > len_reg) ? need_reg : len_reg;
                end
            end
            bpue_pkg::ST_POST_ALIGN: begin
                // drop the bits ahead of the field and keep its width
                win_next = {8'h00, VW'(win_reg >> pos_reg[2:0]) & bpue_pkg::ones64(weff_reg)};
            end
            bpue_pkg::ST_POST_ORDER: begin
                if (be_reg) begin
                    win_next = {8'h00,
                                bpue_pkg::rev64(win_reg[VW-1:0] << (WW'(VW) - weff_reg))};
                end
            end
            bpue_pkg::ST_POST_SIGN: begin
                if (sgn_reg && (weff_reg != '0) && win_reg[sign_idx]) begin
                    win_next = {8'h00, win_reg[VW-1:0] | ~bpue_pkg::ones64(weff_reg)};
                end
            end
            bpue_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_read_value_next   = rv_live_reg ? win_reg[VW-1:0] : '0;
                    m_end_position_next = endp_reg;
                    m_byte_count_next   = len_reg;
                    m_status_next       = status_reg;
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpue_pkg::ST_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        req_reg            <= req_next;
        be_reg             <= be_next;
        sgn_reg            <= sgn_next;
        pos_reg            <= pos_next;
        w_reg              <= w_next;
        val_reg            <= val_next;
        win_reg            <= win_next;
        mask_reg           <= mask_next;
        weff_reg           <= weff_next;
        need_reg           <= need_next;
        first_reg          <= first_next;
        nb_reg             <= nb_next;
        rd_addr_reg        <= rd_addr_next;
        rd_cnt_reg         <= rd_cnt_next;
        pend_addr_reg      <= pend_addr_next;
        fill_reg           <= fill_next;
        endp_reg           <= endp_next;
        status_reg         <= status_next;
        rv_live_reg        <= rv_live_next;
        m_read_value_reg   <= m_read_value_next;
        m_end_position_reg <= m_end_position_next;
        m_byte_count_reg   <= m_byte_count_next;
        m_status_reg       <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_read_value   = $signed(m_read_value_reg);
    assign m_end_position = m_end_position_reg;
    assign m_byte_count   = m_byte_count_reg;
    assign m_status       = m_status_reg;

endmodule
